>>> sv/acc_pkg.sv
// types, codes and helpers shared by the alarm clock controller
package acc_pkg;

	// item kinds
	localparam logic [1:0] KIND_TICK    = 2'd0;
	localparam logic [1:0] KIND_ADV_MIN = 2'd1;
	localparam logic [1:0] KIND_ADV_HR  = 2'd2;
	localparam logic [1:0] KIND_TOGGLE  = 2'd3;

	// advance targets
	localparam logic TARGET_CLOCK = 1'b0;
	localparam logic TARGET_ALARM = 1'b1;

	// time limits and reset values
	localparam logic [4:0] HOUR_LAST        = 5'd23;
	localparam logic [5:0] MINUTE_LAST      = 6'd59;
	localparam logic [7:0] RELOAD_RESET     = 8'd5;
	localparam logic [4:0] ALARM_HOUR_RESET = 5'd11;

	typedef struct packed {
		logic [1:0] kind;
		logic       target;
		logic [4:0] rtc_hours;
		logic [5:0] rtc_minutes;
	} in_item_t;

	typedef struct packed {
		logic [4:0] time_hours;
		logic [5:0] time_minutes;
		logic [4:0] alarm_hours_out;
		logic [5:0] alarm_minutes_out;
		logic       armed_out;
		logic       ringing_out;
		logic       buzzer_on;
		logic       redraw_time;
		logic       redraw_alarm;
		logic       write_rtc;
	} out_item_t;

	typedef logic [7:0] reload_t;

	// hour advance with wrap to zero
	function automatic logic [4:0] next_hour(input logic [4:0] h);
		next_hour = (h >= HOUR_LAST) ? 5'd0 : h + 5'd1;
	endfunction

endpackage

>>> sv/acc_stream_if.sv
// valid/ready channel carrying one payload per transaction
interface acc_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/acc_state.sv
// clock, alarm and buzzer state with its update on each accepted item
module acc_state
	import acc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  in_item_t  item,
	input  reload_t   reload,
	output out_item_t result
);

	logic [4:0] clock_hours_q, seen_hours_q, alarm_hours_q, seen_alarm_hours_q;
	logic [5:0] clock_minutes_q, seen_minutes_q, alarm_minutes_q, seen_alarm_minutes_q;
	logic       armed_q, ringing_q, tone_running_q, next_tone_on_q;
	logic [7:0] tone_divider_q;

	logic [4:0] ch_n, ah_n, sh_n, sah_n;
	logic [5:0] cm_n, am_n, sm_n, sam_n;
	logic       armed_n, ringing_n, tone_n, next_tone_n, rt, ra, wr, match;
	logic [7:0] div_n;

	// next state for one item
	always_comb begin
		ch_n = clock_hours_q;
		cm_n = clock_minutes_q;
		ah_n = alarm_hours_q;
		am_n = alarm_minutes_q;
		sh_n = seen_hours_q;
		sm_n = seen_minutes_q;
		sah_n = seen_alarm_hours_q;
		sam_n = seen_alarm_minutes_q;
		armed_n = armed_q;
		ringing_n = ringing_q;
		tone_n = tone_running_q;
		next_tone_n = next_tone_on_q;
		div_n = tone_divider_q;
		rt = 1'b0;
		ra = 1'b0;
		wr = 1'b0;
		match = (item.rtc_hours == alarm_hours_q) && (item.rtc_minutes == alarm_minutes_q);
		case (item.kind)
			KIND_TICK: begin
				ch_n = item.rtc_hours;
				cm_n = item.rtc_minutes;
				rt = (seen_hours_q != item.rtc_hours) || (seen_minutes_q != item.rtc_minutes);
				ra = (seen_alarm_hours_q != alarm_hours_q) ||
					(seen_alarm_minutes_q != alarm_minutes_q);
				if (rt && match && armed_q) begin
					ringing_n = 1'b1;
				end
				// buzzer divider runs only while armed and ringing
				if (armed_q && ringing_n) begin
					if (tone_divider_q == 8'd0) begin
						tone_n = next_tone_on_q;
						next_tone_n = ~next_tone_on_q;
						div_n = reload;
					end else begin
						div_n = tone_divider_q - 8'd1;
					end
				end else begin
					ringing_n = 1'b0;
					tone_n = 1'b0;
				end
				sh_n = item.rtc_hours;
				sm_n = item.rtc_minutes;
				sah_n = alarm_hours_q;
				sam_n = alarm_minutes_q;
			end
			KIND_ADV_MIN: begin
				if (item.target == TARGET_CLOCK) begin
					wr = 1'b1;
					if (clock_minutes_q >= MINUTE_LAST) begin
						cm_n = 6'd0;
						ch_n = next_hour(clock_hours_q);
					end else begin
						cm_n = clock_minutes_q + 6'd1;
					end
				end else begin
					if (alarm_minutes_q >= MINUTE_LAST) begin
						am_n = 6'd0;
						ah_n = next_hour(alarm_hours_q);
					end else begin
						am_n = alarm_minutes_q + 6'd1;
					end
				end
			end
			KIND_ADV_HR: begin
				if (item.target == TARGET_CLOCK) begin
					wr = 1'b1;
					ch_n = next_hour(clock_hours_q);
				end else begin
					ah_n = next_hour(alarm_hours_q);
				end
			end
			default: begin
				armed_n = ~armed_q;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hours_q <= 5'd0;
			clock_minutes_q <= 6'd0;
			seen_hours_q <= 5'd0;
			seen_minutes_q <= 6'd0;
			alarm_hours_q <= ALARM_HOUR_RESET;
			alarm_minutes_q <= 6'd0;
			seen_alarm_hours_q <= 5'd0;
			seen_alarm_minutes_q <= 6'd0;
			armed_q <= 1'b0;
			ringing_q <= 1'b0;
			tone_divider_q <= RELOAD_RESET;
			tone_running_q <= 1'b0;
			next_tone_on_q <= 1'b1;
		end else if (accept) begin
			clock_hours_q <= ch_n;
			clock_minutes_q <= cm_n;
			seen_hours_q <= sh_n;
			seen_minutes_q <= sm_n;
			alarm_hours_q <= ah_n;
			alarm_minutes_q <= am_n;
			seen_alarm_hours_q <= sah_n;
			seen_alarm_minutes_q <= sam_n;
			armed_q <= armed_n;
			ringing_q <= ringing_n;
			tone_divider_q <= div_n;
			tone_running_q <= tone_n;
			next_tone_on_q <= next_tone_n;
		end
	end

	// result of this item, taken after the update
	always_comb begin
		result.time_hours = ch_n;
		result.time_minutes = cm_n;
		result.alarm_hours_out = ah_n;
		result.alarm_minutes_out = am_n;
		result.armed_out = armed_n;
		result.ringing_out = ringing_n;
		result.buzzer_on = tone_n;
		result.redraw_time = rt;
		result.redraw_alarm = ra;
		result.write_rtc = wr;
	end

endmodule

>>> sv/alarm_clock_controller_unit.sv
// Alarm clock controller: one result per item, one item per cycle while the skid stage
// is empty. The state update is combinational logic on the accepted item; the result is
// registered in an output stage backed by a skid stage, so input is taken while a result
// waits and stalls only when both stages are full. The buzzer reload register is always
// ready; a new value is loaded into the divider when it next runs out on a tick.
module alarm_clock_controller_unit
	import acc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	acc_stream_if.sink   in_item,
	acc_stream_if.source out_item,
	acc_stream_if.sink   cfg
);

	reload_t   reload_q;
	out_item_t result;
	out_item_t out_q, skid_q;
	logic      out_valid_q, skid_valid_q;
	logic      accept, pop;

	assign in_item.ready = ~skid_valid_q;
	assign accept = in_item.valid & in_item.ready;
	assign pop = out_valid_q & out_item.ready;
	assign out_item.valid = out_valid_q;
	assign out_item.data = out_q;
	assign cfg.ready = 1'b1;

	// buzzer reload register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= RELOAD_RESET;
		end else if (cfg.valid) begin
			reload_q <= cfg.data;
		end
	end

	acc_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (in_item.data),
		.reload (reload_q),
		.result (result)
	);

	// output stage with skid behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			// output stays full on a new transaction or while the skid refills it
			out_valid_q <= accept | (out_valid_q & ~(pop & ~skid_valid_q));
			// skid fills when a transaction arrives behind a waiting result
			skid_valid_q <= (skid_valid_q & ~pop) | (accept & out_valid_q & ~pop);
		end
	end

	// payload of the two stages
	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end else if (accept && (!out_valid_q || pop)) begin
			out_q <= result;
		end
		if (accept && out_valid_q && !pop) begin
			skid_q <= result;
		end
	end

endmodule

>>> dv/acc_checker.sv
// alarm clock controller checker: predicts each status transaction and compares it
module acc_checker
	import acc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	input  logic      cfg_valid,
	input  logic      cfg_ready,
	input  reload_t   cfg_data,
	output int        errors,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// predicted controller state
	reload_t    reload;
	logic [4:0] clk_hr, seen_hr, alm_hr, seen_alm_hr;
	logic [5:0] clk_min, seen_min, alm_min, seen_alm_min;
	logic       armed, ringing, tone, next_tone;
	logic [7:0] divider;

	out_item_t  predicted_status[$];
	out_item_t  want;

	function automatic logic [4:0] bump_hour(input logic [4:0] h);
		return (h >= HOUR_LAST) ? 5'd0 : h + 5'd1;
	endfunction

	// minute advance carrying into the hour
	function automatic void bump_minute(inout logic [5:0] m, inout logic [4:0] h);
		if (m >= MINUTE_LAST) begin
			m = 6'd0;
			h = bump_hour(h);
		end else begin
			m = m + 6'd1;
		end
	endfunction

	// apply one input transaction and return the status it should produce
	function automatic out_item_t next_status(input in_item_t it);
		out_item_t r;
		logic      moved;
		r = '0;
		case (it.kind)
			KIND_TICK: begin
				clk_hr = it.rtc_hours;
				clk_min = it.rtc_minutes;
				moved = (seen_hr != clk_hr) || (seen_min != clk_min);
				r.redraw_time = moved;
				if (moved && clk_hr == alm_hr && clk_min == alm_min && armed)
					ringing = 1'b1;
				r.redraw_alarm = (seen_alm_hr != alm_hr) || (seen_alm_min != alm_min);
				// buzzer divider runs only while armed and ringing
				if (armed && ringing) begin
					if (divider == 8'd0) begin
						tone = next_tone;
						next_tone = ~next_tone;
						divider = reload;
					end else begin
						divider = divider - 8'd1;
					end
				end else begin
					ringing = 1'b0;
					tone = 1'b0;
				end
				seen_hr = clk_hr;
				seen_min = clk_min;
				seen_alm_hr = alm_hr;
				seen_alm_min = alm_min;
			end
			KIND_ADV_MIN: begin
				if (it.target == TARGET_CLOCK) begin
					bump_minute(clk_min, clk_hr);
					r.write_rtc = 1'b1;
				end else begin
					bump_minute(alm_min, alm_hr);
				end
			end
			KIND_ADV_HR: begin
				if (it.target == TARGET_CLOCK) begin
					clk_hr = bump_hour(clk_hr);
					r.write_rtc = 1'b1;
				end else begin
					alm_hr = bump_hour(alm_hr);
				end
			end
			default: begin
				armed = ~armed;
			end
		endcase
		r.time_hours = clk_hr;
		r.time_minutes = clk_min;
		r.alarm_hours_out = alm_hr;
		r.alarm_minutes_out = alm_min;
		r.armed_out = armed;
		r.ringing_out = ringing;
		r.buzzer_on = tone;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	// track transactions on all three channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload = RELOAD_RESET;
			clk_hr = '0;
			clk_min = '0;
			seen_hr = '0;
			seen_min = '0;
			alm_hr = ALARM_HOUR_RESET;
			alm_min = '0;
			seen_alm_hr = '0;
			seen_alm_min = '0;
			armed = 1'b0;
			ringing = 1'b0;
			divider = RELOAD_RESET;
			tone = 1'b0;
			next_tone = 1'b1;
			predicted_status.delete();
			errors = 0;
			pending = 0;
		end else begin
			// compare status against the oldest prediction
			if (out_valid && out_ready) begin
				if (predicted_status.size() == 0) begin
					errors++;
					$display("%0t: unexpected status, expected none actual %h", $time,
						out_data);
				end else begin
					want = predicted_status.pop_front();
					check_field("time_hours", 8'(want.time_hours),
						8'(out_data.time_hours));
					check_field("time_minutes", 8'(want.time_minutes),
						8'(out_data.time_minutes));
					check_field("alarm_hours_out", 8'(want.alarm_hours_out),
						8'(out_data.alarm_hours_out));
					check_field("alarm_minutes_out", 8'(want.alarm_minutes_out),
						8'(out_data.alarm_minutes_out));
					check_field("armed_out", 8'(want.armed_out), 8'(out_data.armed_out));
					check_field("ringing_out", 8'(want.ringing_out),
						8'(out_data.ringing_out));
					check_field("buzzer_on", 8'(want.buzzer_on), 8'(out_data.buzzer_on));
					check_field("redraw_time", 8'(want.redraw_time),
						8'(out_data.redraw_time));
					check_field("redraw_alarm", 8'(want.redraw_alarm),
						8'(out_data.redraw_alarm));
					check_field("write_rtc", 8'(want.write_rtc), 8'(out_data.write_rtc));
				end
			end
			if (cfg_valid && cfg_ready)
				reload = cfg_data;
			if (in_valid && in_ready)
				predicted_status.push_back(next_status(in_data));
			pending = predicted_status.size();
		end
	end

endmodule

>>> dv/alarm_clock_controller_unit_test.sv
// alarm clock controller testbench top: clock, reset, stimulus and verdict
module alarm_clock_controller_unit_test
	import acc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 205;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic calm = 1'b0;
	logic send_idling = 1'b1;
	int   errors;
	int   pending;

	// stimulus mirror of the alarm setting and a walking wall time
	logic [4:0] alarm_h = ALARM_HOUR_RESET;
	logic [5:0] alarm_m = '0;
	logic [4:0] wall_h = '0;
	logic [5:0] wall_m = '0;

	acc_stream_if #(.T(in_item_t))  in_ch ();
	acc_stream_if #(.T(out_item_t)) out_ch ();
	acc_stream_if #(.T(reload_t))   cfg_ch ();

	alarm_clock_controller_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_ch),
		.out_item (out_ch),
		.cfg      (cfg_ch)
	);

	acc_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_data   (in_ch.data),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_data  (out_ch.data),
		.cfg_valid (cfg_ch.valid),
		.cfg_ready (cfg_ch.ready),
		.cfg_data  (cfg_ch.data),
		.errors    (errors),
		.pending   (pending)
	);

	always #2 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
	end

	// run limit
	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

	// status sink with random stall bursts and a stall rate that is redrawn at random
	initial begin
		int cyc;
		int odds;
		cyc = 0;
		odds = 5;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 64 == 0)
				odds = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(2, 8);
			if (!calm && odds != 0 && $urandom_range(0, odds) == 0) begin
				out_ch.ready = 1'b0;
				repeat ($urandom_range(1, 18) - 1) @(negedge clk);
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	function automatic void roll_minute(inout logic [5:0] m, inout logic [4:0] h);
		if (m >= 6'd59) begin
			m = 6'd0;
			h = (h >= 5'd23) ? 5'd0 : h + 5'd1;
		end else begin
			m = m + 6'd1;
		end
	endfunction

	function automatic in_item_t make_item(input logic [1:0] kind, input logic target,
			input logic [4:0] h, input logic [5:0] m);
		in_item_t it;
		it.kind = kind;
		it.target = target;
		it.rtc_hours = h;
		it.rtc_minutes = m;
		return it;
	endfunction

	// mostly ticks that walk toward the alarm time, with button noise
	function automatic in_item_t random_item();
		in_item_t it;
		int       pick;
		int       sub;
		it = make_item(KIND_TICK, 1'($urandom), 5'($urandom), 6'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 62) begin
			sub = $urandom_range(0, 9);
			if (sub < 6) begin
				if ($urandom_range(0, 2) != 0)
					roll_minute(wall_m, wall_h);
			end else if (sub < 8) begin
				wall_h = alarm_h;
				wall_m = (alarm_m >= 6'd2) ? alarm_m - 6'($urandom_range(0, 2)) : alarm_m;
			end
			if (sub != 8) begin
				it.rtc_hours = wall_h;
				it.rtc_minutes = wall_m;
			end
		end else if (pick < 76) begin
			it.kind = KIND_ADV_MIN;
		end else if (pick < 90) begin
			it.kind = KIND_ADV_HR;
		end else begin
			it.kind = KIND_TOGGLE;
		end
		return it;
	endfunction

	// send one input transaction, optionally after an idle burst
	task automatic put_item(input in_item_t it);
		@(negedge clk);
		if (!calm && send_idling && $urandom_range(0, 5) == 0) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data = it;
		do @(posedge clk); while (!in_ch.ready);
		// keep the alarm mirror in step
		if (it.target == TARGET_ALARM && it.kind == KIND_ADV_MIN)
			roll_minute(alarm_m, alarm_h);
		if (it.target == TARGET_ALARM && it.kind == KIND_ADV_HR)
			alarm_h = (alarm_h >= 5'd23) ? 5'd0 : alarm_h + 5'd1;
	endtask

	// stop sending and wait for every predicted status
	task automatic drain();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reload(input reload_t v);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.data = v;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	initial begin
		reload_t reloads[PHASES];
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed: wraps, out-of-range reading, alarm hit and buzzer
		write_reload(8'd2);
		put_item(make_item(KIND_TICK, 1'b0, 5'd0, 6'd0));
		put_item(make_item(KIND_TICK, 1'b1, 5'd31, 6'd63));
		put_item(make_item(KIND_ADV_MIN, TARGET_CLOCK, 5'($urandom), 6'($urandom)));
		put_item(make_item(KIND_ADV_HR, TARGET_CLOCK, 5'($urandom), 6'($urandom)));
		put_item(make_item(KIND_TICK, 1'b0, 5'd23, 6'd59));
		put_item(make_item(KIND_ADV_MIN, TARGET_CLOCK, 5'($urandom), 6'($urandom)));
		put_item(make_item(KIND_TICK, 1'b0, 5'd23, 6'd0));
		put_item(make_item(KIND_ADV_HR, TARGET_CLOCK, 5'($urandom), 6'($urandom)));
		put_item(make_item(KIND_ADV_HR, TARGET_ALARM, 5'($urandom), 6'($urandom)));
		put_item(make_item(KIND_ADV_MIN, TARGET_ALARM, 5'($urandom), 6'($urandom)));
		put_item(make_item(KIND_TOGGLE, 1'b1, 5'($urandom), 6'($urandom)));
		put_item(make_item(KIND_TICK, 1'b0, 5'd12, 6'd0));
		put_item(make_item(KIND_TICK, 1'b0, 5'd12, 6'd1));
		repeat (6) put_item(make_item(KIND_TICK, 1'b0, 5'd12, 6'd1));
		put_item(make_item(KIND_ADV_MIN, TARGET_ALARM, 5'($urandom), 6'($urandom)));
		put_item(make_item(KIND_TOGGLE, 1'b0, 5'($urandom), 6'($urandom)));
		put_item(make_item(KIND_TICK, 1'b0, 5'd12, 6'd1));
		put_item(make_item(KIND_TOGGLE, 1'b0, 5'($urandom), 6'($urandom)));
		drain();

		// random phases, reload changed only while idle
		reloads[0] = 8'd0;
		reloads[1] = 8'd255;
		reloads[2] = 8'd1;
		reloads[3] = reload_t'($urandom);
		reloads[4] = RELOAD_RESET;
		reloads[5] = reload_t'($urandom_range(0, 7));
		for (int p = 0; p < PHASES; p++) begin
			write_reload(reloads[p]);
			calm = (p == PHASES - 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 50 == 0)
					send_idling = ($urandom_range(0, 3) != 0);
				put_item(random_item());
			end
			drain();
		end

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
